FILE: hw/rtl/scfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfb_pkg
// Types, codes and helpers shared by the station connection sequencer.
// ----------------------------------------------------------------------------
package scfb_pkg;

    localparam int SLOT_IDX_W = 3;
    localparam int TICK_W     = 21;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TICK_W-1:0]     TICK_MAX             = 21'h1F_FFFF;
    localparam logic [CFG_DATA_W-1:0] CONNECT_TIMEOUT_INIT = 20'd7000;
    localparam logic [CFG_DATA_W-1:0] RETRY_INTERVAL_INIT  = 20'd30000;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MASK       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL  = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BOOT = 3'd1,
        MODE_CONN = 3'd2,
        MODE_UP   = 3'd3,
        MODE_RECO = 3'd4,
        MODE_AP   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    typedef struct packed {
        mode_t                 mode;
        logic [SLOT_IDX_W-1:0] slot;
        logic [TICK_W-1:0]     attempt_ticks;
        logic [TICK_W-1:0]     since_retry_ticks;
        logic                  attempt_pending;
        logic [7:0]            round_failures;
        logic                  fallback;
    } seq_state_t;

    typedef struct packed {
        logic [7:0]            failed_rounds;
        logic                  ap_only_mode;
        logic                  ap_enable;
        logic [SLOT_IDX_W-1:0] connect_slot;
        logic                  connect_request;
        logic [2:0]            state_code;
    } seq_result_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] idx;
    } slot_hit_t;

    // Lowest set mask bit at or above the start position.
    function automatic slot_hit_t find_slot(input logic [7:0] mask, input logic [3:0] from);
        slot_hit_t hit;
        hit.found = 1'b0;
        hit.idx   = '0;
        for (int i = 7; i >= 0; i--) begin
            if (mask[i] && (4'(i) >= from)) begin
                hit.found = 1'b1;
                hit.idx   = SLOT_IDX_W'(i);
            end
        end
        return hit;
    endfunction

endpackage

FILE: hw/rtl/scfb_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfb_cfg_regs
// Configuration registers: slot mask, attempt timeout and retry interval.
// ----------------------------------------------------------------------------
module scfb_cfg_regs #(
    parameter int MASK_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [scfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scfb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [MASK_BITS-1:0]               slot_mask,
    output logic [scfb_pkg::CFG_DATA_W-1:0]    connect_timeout,
    output logic [scfb_pkg::CFG_DATA_W-1:0]    retry_interval
);

    logic [MASK_BITS-1:0]            slot_mask_reg;
    logic [scfb_pkg::CFG_DATA_W-1:0] connect_timeout_reg;
    logic [scfb_pkg::CFG_DATA_W-1:0] retry_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_mask_reg       <= '0;
            connect_timeout_reg <= scfb_pkg::CONNECT_TIMEOUT_INIT;
            retry_interval_reg  <= scfb_pkg::RETRY_INTERVAL_INIT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                scfb_pkg::CFG_SLOT_MASK:       slot_mask_reg       <= cfg_data[MASK_BITS-1:0];
                scfb_pkg::CFG_CONNECT_TIMEOUT: connect_timeout_reg <= cfg_data;
                scfb_pkg::CFG_RETRY_INTERVAL:  retry_interval_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign slot_mask       = slot_mask_reg;
    assign connect_timeout = connect_timeout_reg;
    assign retry_interval  = retry_interval_reg;

endmodule

FILE: hw/rtl/scfb_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfb_step
// Next-state and result logic of the connection sequencer for one item.
// ----------------------------------------------------------------------------
module scfb_step #(
    parameter int MASK_BITS = 8
) (
    input  scfb_pkg::kind_t                    kind,
    input  logic                               link_up,
    input  scfb_pkg::seq_state_t               cur,
    input  logic [MASK_BITS-1:0]               slot_mask,
    input  logic [scfb_pkg::CFG_DATA_W-1:0]    connect_timeout,
    input  logic [scfb_pkg::CFG_DATA_W-1:0]    retry_interval,
    output scfb_pkg::seq_state_t               nxt,
    output scfb_pkg::seq_result_t              res
);

    logic [7:0]                        mask8;
    logic [scfb_pkg::TICK_W-1:0]       at_inc;
    logic [scfb_pkg::TICK_W-1:0]       sr_inc;
    logic                              timed_out;
    logic                              retry_due;
    scfb_pkg::slot_hit_t               first_hit;
    scfb_pkg::slot_hit_t               next_hit;
    logic                              req;
    logic                              ap;

    assign mask8     = 8'(slot_mask);
    assign at_inc    = (cur.attempt_ticks == scfb_pkg::TICK_MAX) ?
                       cur.attempt_ticks : cur.attempt_ticks + 21'd1;
    assign sr_inc    = (cur.since_retry_ticks == scfb_pkg::TICK_MAX) ?
                       cur.since_retry_ticks : cur.since_retry_ticks + 21'd1;
    assign timed_out = at_inc > {1'b0, connect_timeout};
    assign retry_due = sr_inc > {1'b0, retry_interval};
    assign first_hit = scfb_pkg::find_slot(mask8, 4'd0);
    assign next_hit  = scfb_pkg::find_slot(mask8, {1'b0, cur.slot} + 4'd1);

    always_comb
    begin
        nxt = cur;
        req = 1'b0;
        ap  = 1'b0;
        unique case (kind)
            scfb_pkg::KIND_START: nxt.mode = scfb_pkg::MODE_BOOT;
            scfb_pkg::KIND_STOP:  nxt.mode = scfb_pkg::MODE_IDLE;
            scfb_pkg::KIND_TICK:
            begin
                nxt.attempt_ticks     = at_inc;
                nxt.since_retry_ticks = sr_inc;
                unique case (cur.mode)
                    scfb_pkg::MODE_BOOT:
                    begin
                        if (first_hit.found)
                        begin
                            nxt.slot            = first_hit.idx;
                            nxt.attempt_ticks   = '0;
                            nxt.attempt_pending = 1'b0;
                            req                 = 1'b1;
                            nxt.mode            = scfb_pkg::MODE_CONN;
                        end
                        else
                        begin
                            nxt.fallback          = 1'b1;
                            nxt.since_retry_ticks = '0;
                            nxt.mode              = scfb_pkg::MODE_AP;
                            ap                    = 1'b1;
                        end
                    end
                    scfb_pkg::MODE_CONN, scfb_pkg::MODE_RECO:
                    begin
                        if (link_up)
                        begin
                            ap                 = 1'b1;
                            nxt.fallback       = 1'b0;
                            nxt.mode           = scfb_pkg::MODE_UP;
                            nxt.round_failures = '0;
                        end
                        else if ((cur.mode == scfb_pkg::MODE_RECO) && cur.attempt_pending)
                        begin
                            if (first_hit.found)
                            begin
                                nxt.slot            = first_hit.idx;
                                nxt.attempt_ticks   = '0;
                                nxt.attempt_pending = 1'b0;
                                req                 = 1'b1;
                            end
                            else
                            begin
                                nxt.fallback          = 1'b1;
                                nxt.since_retry_ticks = '0;
                                nxt.mode              = scfb_pkg::MODE_AP;
                                ap                    = 1'b1;
                            end
                        end
                        else if (timed_out)
                        begin
                            if (next_hit.found)
                            begin
                                nxt.slot            = next_hit.idx;
                                nxt.attempt_ticks   = '0;
                                nxt.attempt_pending = 1'b0;
                                req                 = 1'b1;
                            end
                            else
                            begin
                                if ((cur.mode == scfb_pkg::MODE_RECO) &&
                                    (cur.round_failures != 8'hFF))
                                begin
                                    nxt.round_failures = cur.round_failures + 8'd1;
                                end
                                nxt.fallback          = 1'b1;
                                nxt.since_retry_ticks = '0;
                                nxt.mode              = scfb_pkg::MODE_AP;
                                ap                    = 1'b1;
                            end
                        end
                    end
                    scfb_pkg::MODE_UP:
                    begin
                        if (!link_up)
                        begin
                            nxt.mode            = scfb_pkg::MODE_RECO;
                            nxt.slot            = '0;
                            nxt.attempt_pending = 1'b1;
                            nxt.round_failures  = '0;
                        end
                    end
                    scfb_pkg::MODE_AP:
                    begin
                        if (retry_due)
                        begin
                            if (first_hit.found)
                            begin
                                ap                  = 1'b1;
                                nxt.slot            = first_hit.idx;
                                nxt.attempt_ticks   = '0;
                                nxt.attempt_pending = 1'b0;
                                req                 = 1'b1;
                                nxt.mode            = scfb_pkg::MODE_RECO;
                                nxt.fallback        = 1'b0;
                            end
                            nxt.since_retry_ticks = '0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res.state_code      = nxt.mode;
        res.connect_request = req;
        res.connect_slot    = ((nxt.mode == scfb_pkg::MODE_CONN) ||
                               (nxt.mode == scfb_pkg::MODE_RECO)) ? nxt.slot : '0;
        res.ap_enable       = ap;
        res.ap_only_mode    = nxt.fallback;
        res.failed_rounds   = nxt.round_failures;
    end

endmodule

FILE: hw/rtl/station_connect_fallback_fsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_connect_fallback_fsm_core
// Station connection sequencer with access-point fallback.
// ----------------------------------------------------------------------------
// An item is taken into the input register, the combinational step logic works
// on it, and its result is held in the result register, which offers it.
// One item per cycle while m_tready does not stall the result register; the
// state register is updated together with the result register.
// Reset clears the mode machine, timers and counters and loads the default
// timeout and retry interval; the block is ready as soon as reset is released.
module station_connect_fallback_fsm_core #(
    parameter int SLOTS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [0] link_up
    input  logic [1:0]                         s_tuser,   // [1:0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] state_code, [3] connect_request, [6:4] connect_slot,
    // [7] ap_enable, [8] ap_only_mode, [16:9] failed_rounds
    output logic [23:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int MASK_BITS = (SLOTS < 8) ? SLOTS : 8;

    logic                            in_valid_reg;
    scfb_pkg::kind_t                 kind_reg;
    logic                            link_up_reg;
    logic                            out_valid_reg;
    scfb_pkg::seq_result_t           out_data_reg;
    scfb_pkg::seq_state_t            state_reg;
    scfb_pkg::seq_state_t            state_next;
    scfb_pkg::seq_result_t           result_next;
    logic [MASK_BITS-1:0]            slot_mask;
    logic [scfb_pkg::CFG_DATA_W-1:0] connect_timeout;
    logic [scfb_pkg::CFG_DATA_W-1:0] retry_interval;
    logic                            out_free;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    scfb_cfg_regs #(
        .MASK_BITS (MASK_BITS)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .slot_mask       (slot_mask),
        .connect_timeout (connect_timeout),
        .retry_interval  (retry_interval)
    );

    scfb_step #(
        .MASK_BITS (MASK_BITS)
    ) u_step (
        .kind            (kind_reg),
        .link_up         (link_up_reg),
        .cur             (state_reg),
        .slot_mask       (slot_mask),
        .connect_timeout (connect_timeout),
        .retry_interval  (retry_interval),
        .nxt             (state_next),
        .res             (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            kind_reg    <= scfb_pkg::kind_t'(s_tuser);
            link_up_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: scfb_pkg::MODE_IDLE, default: '0};
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg.failed_rounds, out_data_reg.ap_only_mode,
                       out_data_reg.ap_enable, out_data_reg.connect_slot,
                       out_data_reg.connect_request, out_data_reg.state_code};

endmodule

FILE: hw/rtl/scfb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfb_checker
// Port-level checks of the connection sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module scfb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata
);

    // A stalled result transaction keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_request_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |->
            (m_tdata[2:0] == scfb_pkg::MODE_CONN) ||
            (m_tdata[2:0] == scfb_pkg::MODE_RECO))
        else $error("connection request outside an attempt mode");

    a_slot_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[6:4] != 3'd0) |->
            (m_tdata[2:0] == scfb_pkg::MODE_CONN) ||
            (m_tdata[2:0] == scfb_pkg::MODE_RECO))
        else $error("slot shown outside an attempt mode");

    a_ap_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7] |->
            (m_tdata[2:0] == scfb_pkg::MODE_UP) ||
            (m_tdata[2:0] == scfb_pkg::MODE_RECO) ||
            (m_tdata[2:0] == scfb_pkg::MODE_AP))
        else $error("access point restart in an unexpected mode");

endmodule

bind station_connect_fallback_fsm_core scfb_checker u_scfb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
